// ----- rtl/dbu_pkg.sv -----
// shared types and constants of the dpcm bayer unpacker
// no dependencies; used by every other rtl file
`timescale 1ns / 1ps

package dbu_pkg;

  // field and register widths
  localparam int DIFF_W    = 16;
  localparam int ACC_W     = 32;
  localparam int DIM_W     = 16;
  localparam int COUNT_W   = 24;
  localparam int BYTE_W    = 8;
  localparam int NIBBLE_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // row-start accumulators, one per (row parity, column parity)
  localparam int RSA_DEPTH = 4;
  localparam int RSA_IDX_W = $clog2(RSA_DEPTH);

  // queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [ACC_W-1:0]   SEED_RST       = '0;
  localparam logic [DIM_W-1:0]   ROW_COUNT_RST  = 16'd1;
  localparam logic [DIM_W-1:0]   COL_COUNT_RST  = 16'd1;
  localparam logic [COUNT_W-1:0] BYTE_LIMIT_RST = 24'd1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED       = 2'd0,
    CFG_ROW_COUNT  = 2'd1,
    CFG_COL_COUNT  = 2'd2,
    CFG_BYTE_LIMIT = 2'd3
  } cfg_idx_t;

  // configuration as seen by the front
  typedef struct packed {
    logic [ACC_W-1:0]   seed;
    logic [DIM_W-1:0]   row_count;
    logic [DIM_W-1:0]   col_count;
    logic [COUNT_W-1:0] byte_limit;
  } cfg_t;

  // one request worth of output bytes: one or two bytes
  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic              two;
    logic              done;
  } entry_t;

endpackage

// ----- rtl/dbu_if.sv -----
// handshake channels of the dpcm bayer unpacker: input and result
// depends on dbu_pkg for field widths
`timescale 1ns / 1ps

interface dbu_in_if;
  import dbu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     start_frame;
  logic signed [DIFF_W-1:0] diff;

  modport source (output valid, output start_frame, output diff, input ready);
  modport sink   (input valid, input start_frame, input diff, output ready);
endinterface

interface dbu_out_if;
  import dbu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              frame_done;

  modport source (output valid, output out_byte, output run_last, output frame_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_done,
                  output ready);
endinterface

// ----- rtl/dbu_front.sv -----
// front part: accepts requests, runs the predictor and packs bytes into queue entries
// depends on dbu_pkg and dbu_if
`timescale 1ns / 1ps

module dbu_front (
  input  logic            clk,
  input  logic            rst_n,
  dbu_in_if.sink          in_chan,
  input  dbu_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            q_push,
  output dbu_pkg::entry_t q_entry
);
  import dbu_pkg::*;

  logic [ACC_W-1:0]    rsa_r [RSA_DEPTH];
  logic [ACC_W-1:0]    rsa_nxt [RSA_DEPTH];
  logic [ACC_W-1:0]    col_acc_r [2];
  logic [ACC_W-1:0]    col_acc_nxt [2];
  logic [DIM_W-1:0]    row_r, row_nxt;
  logic [DIM_W-1:0]    col_r, col_nxt;
  logic                odd_r, odd_nxt;
  logic [NIBBLE_W-1:0] pend_r, pend_nxt;
  logic [COUNT_W-1:0]  bytes_r, bytes_nxt;
  logic                fin_r, fin_nxt;

  // effective state after an optional frame restart
  logic [ACC_W-1:0]    e_rsa [RSA_DEPTH];
  logic [DIM_W-1:0]    e_row, e_col;
  logic                e_odd, e_fin;
  logic [NIBBLE_W-1:0] e_pend;
  logic [COUNT_W-1:0]  e_bytes;

  logic                accept;
  logic                init;
  logic [ACC_W-1:0]    d_ext;
  logic                first;
  logic [RSA_IDX_W-1:0] par;
  logic [ACC_W-1:0]    prev;
  logic [ACC_W-1:0]    value;
  logic [COUNT_W-1:0]  bytes1, bytes2;
  logic                lim1, lim2;
  logic [DIM_W-1:0]    col_inc, row_inc;
  logic                stop;
  entry_t              entry;

  assign in_chan.ready = !q_full;
  assign accept = in_chan.valid && !q_full;
  assign init   = in_chan.start_frame;

  // restart view of the state
  always_comb begin
    for (int i = 0; i < RSA_DEPTH; i++) begin
      e_rsa[i] = init ? cfg.seed : rsa_r[i];
    end
    e_row   = init ? '0 : row_r;
    e_col   = init ? '0 : col_r;
    e_odd   = init ? 1'b0 : odd_r;
    e_pend  = init ? '0 : pend_r;
    e_bytes = init ? '0 : bytes_r;
    e_fin   = init ? 1'b0 : fin_r;
  end

  // prediction and byte counts
  always_comb begin
    d_ext   = {{(ACC_W-DIFF_W){in_chan.diff[DIFF_W-1]}}, in_chan.diff};
    first   = (e_col[DIM_W-1:1] == '0);
    par     = {e_row[0], e_col[0]};
    prev    = first ? e_rsa[par] : col_acc_r[e_col[0]];
    value   = prev + d_ext;
    bytes1  = e_bytes + COUNT_W'(1);
    bytes2  = e_bytes + COUNT_W'(2);
    lim1    = (bytes1 >= cfg.byte_limit);
    lim2    = (bytes2 >= cfg.byte_limit);
    col_inc = e_col + DIM_W'(1);
    row_inc = e_row + DIM_W'(1);
  end

  // next state and queue entry
  always_comb begin
    rsa_nxt     = rsa_r;
    col_acc_nxt = col_acc_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    odd_nxt     = odd_r;
    pend_nxt    = pend_r;
    bytes_nxt   = bytes_r;
    fin_nxt     = fin_r;
    entry       = '0;
    stop        = 1'b0;
    q_push      = 1'b0;
    if (accept) begin
      rsa_nxt   = e_rsa;
      row_nxt   = e_row;
      col_nxt   = e_col;
      odd_nxt   = e_odd;
      pend_nxt  = e_pend;
      bytes_nxt = e_bytes;
      fin_nxt   = e_fin;
      if (e_fin) begin
        // frame over: nothing until a restart
      end else if (cfg.col_count == '0 || e_row >= cfg.row_count) begin
        fin_nxt = 1'b1;
      end else begin
        q_push = 1'b1;
        col_acc_nxt[e_col[0]] = value;
        if (first) begin
          rsa_nxt[par] = value;
        end
        if (!e_odd) begin
          // even value: high byte now, low nibble kept
          entry.b0  = value[11:4];
          bytes_nxt = bytes1;
          if (lim1) begin
            stop    = 1'b1;
            fin_nxt = 1'b1;
          end else begin
            pend_nxt = value[3:0];
            odd_nxt  = 1'b1;
          end
        end else begin
          // odd value: pending nibble joins the top bits, then the low byte
          entry.b0 = {e_pend, value[11:8]};
          entry.b1 = value[7:0];
          odd_nxt  = 1'b0;
          pend_nxt = '0;
          if (lim1) begin
            stop      = 1'b1;
            bytes_nxt = bytes1;
            fin_nxt   = 1'b1;
          end else begin
            entry.two = 1'b1;
            bytes_nxt = bytes2;
            stop      = lim2;
            fin_nxt   = lim2;
          end
        end
        // grid walk and trailing nibble at the end of the grid
        if (!stop) begin
          col_nxt = col_inc;
          if (col_inc >= cfg.col_count) begin
            col_nxt = '0;
            row_nxt = row_inc;
            if (row_inc >= cfg.row_count) begin
              fin_nxt = 1'b1;
              if (!e_odd) begin
                entry.b1  = {value[3:0], {NIBBLE_W{1'b0}}};
                entry.two = 1'b1;
                bytes_nxt = bytes2;
                odd_nxt   = 1'b0;
                pend_nxt  = '0;
              end
            end
          end
        end
        entry.done = fin_nxt;
      end
    end
  end

  assign q_entry = entry;

  // control state and row-start accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RSA_DEPTH; i++) begin
        rsa_r[i] <= SEED_RST;
      end
      row_r   <= '0;
      col_r   <= '0;
      odd_r   <= 1'b0;
      pend_r  <= '0;
      bytes_r <= '0;
      fin_r   <= 1'b0;
    end else begin
      rsa_r   <= rsa_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      odd_r   <= odd_nxt;
      pend_r  <= pend_nxt;
      bytes_r <= bytes_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // column accumulators, always written before they are read
  always_ff @(posedge clk) begin
    col_acc_r <= col_acc_nxt;
  end

endmodule

// ----- rtl/dbu_queue.sv -----
// short fifo of byte entries between the front and the back
// depends on dbu_pkg
`timescale 1ns / 1ps

module dbu_queue #(
  parameter int Depth = dbu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dbu_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            head_valid,
  output dbu_pkg::entry_t head,
  output logic            full
);
  import dbu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t          mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == CntW'(Depth));
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/dbu_back.sv -----
// back part: splits queue entries into single bytes on a registered result channel
// depends on dbu_pkg and dbu_if
`timescale 1ns / 1ps

module dbu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  dbu_pkg::entry_t head,
  output logic            pop,
  dbu_out_if.source       out_chan
);
  import dbu_pkg::*;

  logic              valid_r, valid_nxt;
  logic              phase_r, phase_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              done_r, done_nxt;
  logic              load;

  assign out_chan.valid      = valid_r;
  assign out_chan.out_byte   = byte_r;
  assign out_chan.run_last   = last_r;
  assign out_chan.frame_done = done_r;

  // output register refills when empty or taken
  always_comb begin
    load      = !valid_r || out_chan.ready;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = head_valid;
      if (head_valid) begin
        if (phase_r) begin
          byte_nxt  = head.b1;
          last_nxt  = 1'b1;
          done_nxt  = head.done;
          phase_nxt = 1'b0;
          pop       = 1'b1;
        end else begin
          byte_nxt  = head.b0;
          last_nxt  = !head.two;
          done_nxt  = head.done && !head.two;
          phase_nxt = head.two;
          pop       = !head.two;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
  end

endmodule

// ----- rtl/dpcm_bayer_unpack_12bit.sv -----
// DPCM decoder with 2x2 row-start prediction and 12-bit packing, and its register file.
// A request carries one decoded difference; the front handles it in the cycle it is taken
// and queues one or two bytes, the back sends one byte per cycle on a registered output
// while the result channel is ready. An item that yields one byte can be taken every cycle
// under the same condition, one that yields two bytes sends both on the one-byte channel, so
// the steady rate is set by the byte count per item on the one-byte result channel: three
// bytes per pair of values for a stream of values. Items after the end of a frame, or over
// an empty grid, produce no bytes and are taken whenever the queue is not full.
// depends on dbu_pkg, dbu_if, dbu_front, dbu_queue and dbu_back
`timescale 1ns / 1ps

module dpcm_bayer_unpack_12bit #(
  parameter int QueueDepth = dbu_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dbu_in_if.sink                         in_chan,
  dbu_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [dbu_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [dbu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbu_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   q_push, q_pop, q_full, q_head_valid;
  entry_t q_entry, q_head;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SEED:       cfg_nxt.seed       = cfg_data[ACC_W-1:0];
        CFG_ROW_COUNT:  cfg_nxt.row_count  = cfg_data[DIM_W-1:0];
        CFG_COL_COUNT:  cfg_nxt.col_count  = cfg_data[DIM_W-1:0];
        CFG_BYTE_LIMIT: cfg_nxt.byte_limit = cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed       <= SEED_RST;
      cfg_r.row_count  <= ROW_COUNT_RST;
      cfg_r.col_count  <= COL_COUNT_RST;
      cfg_r.byte_limit <= BYTE_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dbu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  dbu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head),
    .full       (q_full)
  );

  dbu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule

// ----- rtl/dbu_checker.sv -----
// port-level checks of the dpcm bayer unpacker, bound to the top level
// depends on dbu_pkg; attached by the bind at the end of this file
`timescale 1ns / 1ps

module dbu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [dbu_pkg::BYTE_W-1:0] out_byte,
  input logic                       out_run_last,
  input logic                       out_frame_done
);

  // output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a byte that ends the frame is also the last byte of its request
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_run_last)
    else $error("frame end on a byte that is not the last of its request");

  // a stalled result stays offered
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its byte
  a_byte_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("result byte changed while stalled");

endmodule

bind dpcm_bayer_unpack_12bit dbu_checker u_dbu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_byte       (out_chan.out_byte),
  .out_run_last   (out_chan.run_last),
  .out_frame_done (out_chan.frame_done)
);
